### sv/fskc_pkg.sv
// Package for the feedback soft-knee compressor: widths, fixed-point constants,
// register indexes and the 2^(1/2^k) factor table used by the dB-to-linear step.
// No dependencies.
package fskc_pkg;

	localparam int CHANNELS = 2;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int SAMPLE_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAKEUP = 3'd5;

	localparam logic signed [15:0] DB_FLOOR = -16'sd24576;
	localparam logic [31:0] K_DB = 32'd101008905;
	localparam logic [31:0] K_LIN = 32'd2786635;

	typedef logic [16:0][31:0] r_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] x;
		int i;
		res = '0;
		bit_v = 64'h4000_0000_0000_0000;
		x = v;
		for (i = 0; i < 32; i++) begin
			if (bit_v > x) bit_v = bit_v >> 2;
		end
		for (i = 0; i < 32; i++) begin
			if (bit_v != 64'd0) begin
				if (x >= res + bit_v) begin
					x = x - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
		end
		return res;
	endfunction

	function automatic r_tab_t build_rtab();
		r_tab_t t;
		int k;
		t[0] = 32'h8000_0000;
		for (k = 1; k <= 16; k++) begin
			t[k] = 32'(isqrt64({32'd0, t[k-1]} << 30));
		end
		return t;
	endfunction

	localparam r_tab_t R_TAB = build_rtab();

endpackage

### sv/fskc_if.sv
// Valid/ready channel interfaces for samples in and compressed samples out.
// Depends on fskc_pkg.
interface fskc_in_if;
	logic valid;
	logic ready;
	logic signed [fskc_pkg::SAMPLE_W-1:0] sample_in;
	logic channel;
	modport source (output valid, output sample_in, output channel, input ready);
	modport sink (input valid, input sample_in, input channel, output ready);
endinterface

interface fskc_out_if;
	logic valid;
	logic ready;
	logic signed [fskc_pkg::SAMPLE_W-1:0] sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

### sv/feedback_soft_knee_compressor_unit.sv
// Feedback soft-knee compressor, top level: sequencer around one shared 32x32 multiplier
// and a restoring divider. Depends on fskc_pkg and fskc_if.
//
// Usage: samples (sink) takes sample_in and channel; results (source) gives sample_out.
// Registers (cfg_we / cfg_index / cfg_data): the user writes them only while idle; the block does not enforce it.
// One sample is taken, then samples.ready stays low until its result is in the output
// register. Each sample runs a log pass on the previous output of its channel (when
// nonzero), the gain curve with a 34-step divide (when on the curve), the gain
// smoothing, a log pass on the input (when nonzero) and the exponent table multiply.
// A log pass shifts the 24-bit magnitude until normalized, then takes 16 squarings.
// The output register lets the next sample be taken while a result waits. If the
// receiver stalls, the sequencer holds its finished result and the channel state is
// updated only when that result moves into the output register.
// Reset: registers take their defaults, prev output and smoothed gain of every
// channel clear to zero, no result is pending.
module feedback_soft_knee_compressor_unit (
	input logic clk,
	input logic arst_n,
	fskc_in_if.sink samples,
	fskc_out_if.source results,
	input logic cfg_we,
	input logic [fskc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fskc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LNORM = 4'd1;
	localparam logic [3:0] ST_LSQ = 4'd2;
	localparam logic [3:0] ST_LMUL = 4'd3;
	localparam logic [3:0] ST_CURV1 = 4'd4;
	localparam logic [3:0] ST_CURV2 = 4'd5;
	localparam logic [3:0] ST_CURV3 = 4'd6;
	localparam logic [3:0] ST_DIV = 4'd7;
	localparam logic [3:0] ST_SM1 = 4'd8;
	localparam logic [3:0] ST_SM2 = 4'd9;
	localparam logic [3:0] ST_EXP1 = 4'd10;
	localparam logic [3:0] ST_EMUL = 4'd11;
	localparam logic [3:0] ST_EFIN = 4'd12;
	localparam logic [3:0] ST_DONE = 4'd13;

	logic [3:0] state_q;

	logic signed [15:0] thr_q;
	logic [12:0] knee_q;
	logic [5:0] ratio_q;
	logic [15:0] att_q;
	logic [15:0] rel_q;
	logic [12:0] makeup_q;

	logic signed [23:0] prev_q [fskc_pkg::CHANNELS];
	logic signed [23:0] sg_q [fskc_pkg::CHANNELS];

	logic signed [23:0] x_q;
	logic [fskc_pkg::CH_IDX_W-1:0] ch_q;
	logic pass_q;
	logic [23:0] m_q;
	logic [4:0] cnt_q;
	logic [15:0] frac_q;
	logic [5:0] iter_q;
	logic signed [15:0] lvl_q;
	logic b1_q;
	logic [31:0] sq_q;
	logic [33:0] num_q;
	logic [22:0] den_q;
	logic [23:0] rem_q;
	logic [15:0] a_q;
	logic [40:0] acc_q;
	logic signed [23:0] gnew_q;
	logic signed [15:0] dd_q;
	logic signed [23:0] l_q;
	logic [31:0] eacc_q;
	logic [23:0] res_q;
	logic out_v_q;
	logic [23:0] out_d_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	logic [fskc_pkg::CH_IDX_W-1:0] ch_sel;
	logic signed [23:0] pv;
	logic [5:0] r_eff;
	logic signed [17:0] d;
	logic signed [18:0] d2;
	logic signed [18:0] wext;
	logic signed [18:0] u;
	logic b1;
	logic b2;
	logic [20:0] n_log;
	logic [63:0] db_sum;
	logic [15:0] db;
	logic [16:0] mc;
	logic signed [17:0] c_s;
	logic signed [23:0] g_cur;
	logic [15:0] a_sel;
	logic [23:0] mg;
	logic [40:0] sm_sum;
	logic signed [25:0] dsum;
	logic signed [25:0] dclamp;
	logic [15:0] ddm;
	logic [39:0] v40;
	logic [23:0] rem_sh;
	logic div_bit;
	logic f_bit;
	logic signed [8:0] sh_full;
	logic [5:0] sh;
	logic [40:0] rnd;
	logic [23:0] sat;
	logic out_load;

	assign samples.ready = (state_q == ST_IDLE);
	assign results.valid = out_v_q;
	assign results.sample_out = out_d_q;
	assign out_load = (state_q == ST_DONE) && (!out_v_q || results.ready);

	always_comb begin
		if (32'(samples.channel) >= fskc_pkg::CHANNELS) begin
			ch_sel = fskc_pkg::CH_IDX_W'(fskc_pkg::CHANNELS - 1);
		end else begin
			ch_sel = fskc_pkg::CH_IDX_W'(samples.channel);
		end
	end
	assign pv = prev_q[ch_sel];

	assign r_eff = (ratio_q == 6'd0) ? 6'd1 : ratio_q;
	assign d = 18'(lvl_q) - 18'(thr_q);
	assign d2 = {d, 1'b0};
	assign wext = $signed({6'd0, knee_q});
	assign u = d2 + wext;
	assign b1 = d2 > wext;
	assign b2 = !b1 && (d2 >= -wext) && (knee_q != 13'd0);

	assign n_log = {cnt_q, 16'd0} - {5'd0, frac_q};
	assign db_sum = mul_p + 64'h0000_0000_8000_0000;
	assign db = db_sum[47:32];

	assign mc = num_q[16:0];
	assign c_s = -$signed({1'b0, mc});
	assign g_cur = sg_q[ch_q];
	assign a_sel = (c_s < g_cur) ? att_q : rel_q;
	assign mg = g_cur[23] ? 24'(-g_cur) : 24'd0;
	assign sm_sum = acc_q + mul_p[40:0] + 41'd32768;

	assign dsum = $signed({{2{gnew_q[23]}}, gnew_q}) - $signed({10'd0, db});
	assign dclamp = (dsum < 26'(fskc_pkg::DB_FLOOR)) ? 26'(fskc_pkg::DB_FLOOR) : dsum;

	assign ddm = dd_q[15] ? 16'(-dd_q) : dd_q;
	assign v40 = (dd_q[15] ? (40'd0 - mul_p[39:0]) : mul_p[39:0]) + 40'd32768;

	assign rem_sh = {rem_q[22:0], num_q[33]};
	assign div_bit = rem_sh >= {1'b0, den_q};

	assign f_bit = l_q[4'(5'd16 - iter_q[4:0])];

	always_comb begin
		sh_full = 9'sd7 - 9'($signed(l_q[23:16]));
		if (sh_full < 9'sd1) begin
			sh = 6'd1;
		end else if (sh_full > 9'sd40) begin
			sh = 6'd40;
		end else begin
			sh = 6'(sh_full);
		end
		rnd = ({9'd0, eacc_q} + (41'd1 << (sh - 6'd1))) >> sh;
		if (x_q[23]) begin
			sat = (rnd > 41'd8388608) ? 24'(-24'sd8388608) : 24'(-rnd[23:0]);
		end else begin
			sat = (rnd > 41'd8388607) ? 24'd8388607 : rnd[23:0];
		end
	end

	always_comb begin
		unique case (state_q)
			ST_LSQ: begin
				mul_a = {8'd0, m_q};
				mul_b = {8'd0, m_q};
			end
			ST_LMUL: begin
				mul_a = {11'd0, n_log};
				mul_b = fskc_pkg::K_DB;
			end
			ST_CURV1: begin
				mul_a = b1 ? {15'd0, d[16:0]} : {17'd0, u[14:0]};
				mul_b = b1 ? 32'd1 : {17'd0, u[14:0]};
			end
			ST_CURV2: begin
				mul_a = sq_q;
				mul_b = {26'd0, r_eff - 6'd1};
			end
			ST_CURV3: begin
				mul_a = {19'd0, knee_q};
				mul_b = {26'd0, r_eff};
			end
			ST_SM1: begin
				mul_a = {15'd0, 17'(17'h10000 - {1'b0, a_sel})};
				mul_b = {15'd0, mc};
			end
			ST_SM2: begin
				mul_a = {16'd0, a_q};
				mul_b = {8'd0, mg};
			end
			ST_EXP1: begin
				mul_a = {16'd0, ddm};
				mul_b = fskc_pkg::K_LIN;
			end
			ST_EMUL: begin
				mul_a = eacc_q;
				mul_b = fskc_pkg::R_TAB[iter_q[4:0]];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			knee_q <= 13'd512;
			ratio_q <= 6'd3;
			att_q <= 16'd65494;
			rel_q <= 16'd65532;
			makeup_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fskc_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				fskc_pkg::REG_KNEE: knee_q <= cfg_data[12:0];
				fskc_pkg::REG_RATIO: ratio_q <= cfg_data[5:0];
				fskc_pkg::REG_ATTACK: att_q <= cfg_data;
				fskc_pkg::REG_RELEASE: rel_q <= cfg_data;
				fskc_pkg::REG_MAKEUP: makeup_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_d_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fskc_pkg::CHANNELS; i++) begin
				prev_q[i] <= '0;
				sg_q[i] <= '0;
			end
		end else if (out_load) begin
			prev_q[ch_q] <= res_q;
			sg_q[ch_q] <= gnew_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) state_q <= (pv == 24'sd0) ? ST_CURV1 : ST_LNORM;
				end
				ST_LNORM: if (m_q[23]) state_q <= ST_LSQ;
				ST_LSQ: if (iter_q == 6'd15) state_q <= ST_LMUL;
				ST_LMUL: state_q <= pass_q ? ST_EXP1 : ST_CURV1;
				ST_CURV1: state_q <= (b1 || b2) ? ST_CURV2 : ST_SM1;
				ST_CURV2: state_q <= ST_CURV3;
				ST_CURV3: state_q <= ST_DIV;
				ST_DIV: if (iter_q == 6'd33) state_q <= ST_SM1;
				ST_SM1: state_q <= ST_SM2;
				ST_SM2: state_q <= (x_q == 24'sd0) ? ST_EXP1 : ST_LNORM;
				ST_EXP1: state_q <= ST_EMUL;
				ST_EMUL: if (iter_q == 6'd16) state_q <= ST_EFIN;
				ST_EFIN: state_q <= ST_DONE;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q <= samples.sample_in;
				ch_q <= ch_sel;
				pass_q <= 1'b0;
				cnt_q <= '0;
				lvl_q <= fskc_pkg::DB_FLOOR;
				m_q <= pv[23] ? 24'(-pv) : pv;
			end
			ST_LNORM: begin
				if (m_q[23]) begin
					iter_q <= '0;
					frac_q <= '0;
				end else begin
					m_q <= {m_q[22:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
				end
			end
			ST_LSQ: begin
				iter_q <= iter_q + 6'd1;
				if (mul_p[47]) begin
					m_q <= mul_p[47:24];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q <= mul_p[46:23];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			ST_LMUL: begin
				if (pass_q) begin
					dd_q <= 16'(dclamp) + {3'd0, makeup_q};
				end else begin
					lvl_q <= (db > 16'd24576) ? fskc_pkg::DB_FLOOR : 16'(-db);
				end
			end
			ST_CURV1: begin
				b1_q <= b1;
				sq_q <= mul_p[31:0];
				num_q <= '0;
			end
			ST_CURV2: begin
				num_q <= mul_p[33:0] + (b1_q ? {29'd0, r_eff[5:1]} : 34'd0);
			end
			ST_CURV3: begin
				den_q <= b1_q ? {17'd0, r_eff} : {mul_p[19:0], 3'd0};
				if (!b1_q) num_q <= num_q + {12'd0, mul_p[19:0], 2'd0};
				rem_q <= '0;
				iter_q <= '0;
			end
			ST_DIV: begin
				iter_q <= iter_q + 6'd1;
				rem_q <= div_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;
				num_q <= {num_q[32:0], div_bit};
			end
			ST_SM1: begin
				a_q <= a_sel;
				acc_q <= mul_p[40:0];
			end
			ST_SM2: begin
				gnew_q <= 24'(-sm_sum[40:16]);
				pass_q <= 1'b1;
				cnt_q <= '0;
				m_q <= x_q[23] ? 24'(-x_q) : x_q;
				dd_q <= fskc_pkg::DB_FLOOR + {3'd0, makeup_q};
			end
			ST_EXP1: begin
				l_q <= v40[39:16];
				eacc_q <= 32'h4000_0000;
				iter_q <= 6'd1;
			end
			ST_EMUL: begin
				if (f_bit) eacc_q <= mul_p[61:30];
				iter_q <= iter_q + 6'd1;
			end
			ST_EFIN: res_q <= sat;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> !samples.ready)
		else $error("sample taken while a sample is in work");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_v_q && !results.ready) |=> (state_q == ST_DONE))
		else $error("finished result dropped under stall");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < {1'b0, den_q}))
		else $error("divider remainder out of range");

	a_exp_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMUL) |-> (!eacc_q[31] && eacc_q[30]))
		else $error("exponent accumulator out of range");

	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LSQ) |-> m_q[23])
		else $error("log mantissa not normalized");
`endif

endmodule

### sim/fskc_checker.sv
// Scoreboard for the feedback soft-knee compressor: watches both channels and the
// register port, predicts each compressed sample and compares. Depends on fskc_pkg, fskc_if.
`timescale 1ns / 100ps
module fskc_checker (
	input logic clk,
	input logic arst_n,
	fskc_in_if samples,
	fskc_out_if results,
	input logic cfg_we,
	input logic [fskc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fskc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int errors,
	output int pending,
	output int checked
);
	import fskc_pkg::*;

	logic signed [15:0] thr;
	logic [12:0] knee;
	logic [5:0] ratio;
	logic [15:0] att, rel;
	logic [12:0] makeup;
	logic signed [23:0] last_out [CHANNELS];
	logic signed [23:0] gain_db [CHANNELS];
	logic signed [23:0] expected_samples [$];
	longint unsigned rfac [17];

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else res = res >> 1;
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint level_db(longint unsigned m);
		int p;
		longint unsigned q, n;
		int unsigned frac;
		p = 23;
		frac = 0;
		while (p > 0 && m[p] == 1'b0) p--;
		q = m << (23 - p);
		for (int i = 0; i < 16; i++) begin
			q = (q * q) >> 23;
			frac = frac << 1;
			if (q >= (64'd1 << 24)) begin
				frac = frac | 1;
				q = q >> 1;
			end
		end
		n = longint'(23 - p) * 65536 - frac;
		return -longint'((n * 101008905 + (64'd1 << 31)) >> 32);
	endfunction

	function automatic longint unsigned db_mag(longint dv);
		longint l, ip, f, sh;
		longint unsigned acc;
		acc = 64'd1 << 30;
		l = floor_shr(dv * 2786635 + 32768, 16);
		ip = floor_shr(l, 16);
		f = l - ip * 65536;
		for (int k = 1; k <= 16; k++)
			if ((f >> (16 - k)) & 1) acc = (acc * rfac[k]) >> 30;
		sh = 7 - ip;
		if (sh < 1) sh = 1;
		if (sh > 40) sh = 40;
		return (acc + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic logic signed [23:0] compress(logic signed [23:0] x, int ch);
		longint t, w, r, pv, lvl, d, c, g, dd, u, den, xv;
		longint unsigned a, mc, mg, mag;
		xv = x;
		t = thr;
		w = knee;
		r = (ratio == 0) ? 1 : ratio;
		pv = last_out[ch];
		if (pv == 0) lvl = -24576;
		else begin
			lvl = level_db(pv < 0 ? -pv : pv);
			if (lvl < -24576) lvl = -24576;
		end
		d = lvl - t;
		if (2 * d > w) c = -((d * (r - 1) + r / 2) / r);
		else if (2 * d >= -w && w != 0) begin
			u = 2 * d + w;
			den = 8 * w * r;
			c = -(((r - 1) * u * u + den / 2) / den);
		end else c = 0;
		g = gain_db[ch];
		a = (c < g) ? att : rel;
		mc = -c;
		mg = (g < 0) ? -g : 0;
		g = -longint'(((65536 - a) * mc + a * mg + 32768) >> 16);
		if (xv == 0) dd = -24576;
		else begin
			dd = level_db(xv < 0 ? -xv : xv) + g;
			if (dd < -24576) dd = -24576;
		end
		dd = dd + makeup;
		mag = db_mag(dd);
		if (xv < 0) begin
			if (mag > 8388608) mag = 8388608;
			xv = -longint'(mag);
		end else begin
			if (mag > 8388607) mag = 8388607;
			xv = mag;
		end
		last_out[ch] = xv;
		gain_db[ch] = g;
		return xv;
	endfunction

	initial begin
		rfac[0] = 64'd1 << 31;
		for (int k = 1; k <= 16; k++) rfac[k] = root64(rfac[k-1] << 30);
	end

	assign pending = expected_samples.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr <= 0;
			knee <= 512;
			ratio <= 3;
			att <= 65494;
			rel <= 65532;
			makeup <= 0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_out[i] = 0;
				gain_db[i] = 0;
			end
			expected_samples.delete();
			errors <= 0;
			checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr <= cfg_data;
					REG_KNEE: knee <= cfg_data[12:0];
					REG_RATIO: ratio <= cfg_data[5:0];
					REG_ATTACK: att <= cfg_data;
					REG_RELEASE: rel <= cfg_data;
					REG_MAKEUP: makeup <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				expected_samples.push_back(compress(samples.sample_in,
					(samples.channel >= CHANNELS) ? CHANNELS - 1 : samples.channel));
			if (results.valid && results.ready) begin
				checked <= checked + 1;
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected transfer, actual %0d", $time, results.sample_out);
					errors <= errors + 1;
				end else if (expected_samples[0] !== results.sample_out) begin
					$display("%0t: sample_out expected %0d actual %0d", $time,
						expected_samples[0], results.sample_out);
					errors <= errors + 1;
					void'(expected_samples.pop_front());
				end else void'(expected_samples.pop_front());
			end
		end
	end
endmodule

### sim/feedback_soft_knee_compressor_unit_test.sv
// Testbench top for the feedback soft-knee compressor: directed and random samples
// over several register settings and idle mixes. Depends on fskc_pkg, fskc_if, fskc_checker, the unit.
`timescale 1ns / 100ps
module feedback_soft_knee_compressor_unit_test;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [fskc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [fskc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int errors, pending, checked;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 0;

	fskc_in_if samples();
	fskc_out_if results();

	feedback_soft_knee_compressor_unit dut (.clk(clk), .arst_n(arst_n), .samples(samples),
		.results(results), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

	fskc_checker scoreboard (.clk(clk), .arst_n(arst_n), .samples(samples), .results(results),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
		.pending(pending), .checked(checked));

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		samples.valid = 0;
		samples.sample_in = '0;
		samples.channel = 0;
		results.ready = 0;
	end

	always @(posedge clk) begin
		if (hold_off) results.ready <= 1'b0;
		else results.ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send(logic signed [23:0] s, logic ch);
		while ($urandom_range(99) < send_idle) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample_in <= s;
		samples.channel <= ch;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [fskc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic set_all(logic [15:0] t, logic [15:0] k, logic [15:0] r,
			logic [15:0] a, logic [15:0] rl, logic [15:0] m);
		write_reg(fskc_pkg::REG_THRESHOLD, t);
		write_reg(fskc_pkg::REG_KNEE, k);
		write_reg(fskc_pkg::REG_RATIO, r);
		write_reg(fskc_pkg::REG_ATTACK, a);
		write_reg(fskc_pkg::REG_RELEASE, rl);
		write_reg(fskc_pkg::REG_MAKEUP, m);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand_sample();
		int shift;
		logic [23:0] v;
		shift = $urandom_range(23);
		v = $urandom();
		if ($urandom_range(3) == 0) return v;
		return signed'(v) >>> shift;
	endfunction

	task automatic random_run(int count);
		for (int i = 0; i < count; i++) send(rand_sample(), $urandom_range(1));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(24'sd0, 0);
		send(24'sd8388607, 0);
		send(-24'sd8388608, 0);
		send(24'sd8388607, 1);
		send(24'sd1, 1);
		send(-24'sd1, 1);
		send(24'sd4194304, 0);
		send(-24'sd100000, 1);
		send(24'sd0, 1);
		drain();
		set_all(16'hE800, 0, 4, 30000, 60000, 0);
		send(24'sd8388607, 0);
		send(24'sd8388607, 0);
		send(24'sd524288, 1);
		send(-24'sd524288, 1);
		drain();
		set_all(16'h0000, 6144, 0, 65535, 0, 6144);
		send(24'sd8388607, 0);
		send(-24'sd8388608, 1);
		send(24'sd0, 0);
		send(24'sd1000, 1);
		drain();
		set_all(16'hA000, 6144, 32, 0, 65535, 0);
		send(24'sd8388607, 0);
		send(24'sd8388607, 0);
		send(-24'sd30000, 1);
		drain();

		random_run(300);
		drain();
		set_all(16'hF400, 1024, 8, 60000, 65000, 512);
		send_idle = 83;
		random_run(150);
		send_idle = 0;
		recv_stall = 83;
		random_run(150);
		send_idle = 17;
		recv_stall = 17;
		random_run(200);
		drain();
		set_all(16'hF000 + $urandom_range(4095), $urandom_range(6144), $urandom_range(1, 32),
			$urandom(), $urandom(), $urandom_range(6144));
		send_idle = 0;
		recv_stall = 0;
		fork
			begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			random_run(20);
		join
		drain();
		set_all(16'sd256, 0, 2, 65535, 65535, 3000);
		random_run(250);
		drain();
		set_all(16'hD000, 3000, 5, $urandom(), $urandom(), 100);
		send_idle = 17;
		recv_stall = 17;
		random_run(250);
		drain();

		$display("Covered %0d results over eight register settings, extreme samples,", checked);
		$display("hard and soft knee, ratio 0..32, idle mixes and a long output hold-off.");
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
